/* rtl/core/ffht_pkg.sv */
// shared types and constants for the first-free-slot handle table
`default_nettype none

package ffht_pkg;

  // operation codes carried by an item
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // field widths
  localparam int KEY_W      = 8;
  localparam int KEY_IDX_W  = 7;
  localparam int WORD_W     = 32;
  localparam int SLOT_W     = 6;

  // input item
  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic [WORD_W-1:0]       value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
  } out_item_t;

  // classified operation passed from front to back
  typedef struct packed {
    kind_t                kind;
    logic                 in_range;
    logic [KEY_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    value;
  } op_t;

endpackage

`default_nettype wire

/* rtl/core/ffht_front.sv */
// front end: accepts items and classifies kind and key range
`default_nettype none

module ffht_front #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ffht_pkg::in_item_t in_data,
  input  wire logic              q_ready,
  output logic                   push,
  output ffht_pkg::op_t          push_op
);
  import ffht_pkg::*;

  // accept whenever the queue has room
  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // decode kind and check that the key is a valid slot index
  always_comb begin
    push_op.kind     = kind_t'(in_data.kind);
    push_op.in_range = !in_data.key[KEY_W-1] &&
                       ({1'b0, in_data.key[KEY_IDX_W-1:0]} < KEY_W'(TABLE_SLOTS));
    push_op.idx      = in_data.key[KEY_IDX_W-1:0];
    push_op.value    = in_data.value;
  end

endmodule

`default_nettype wire

/* rtl/core/ffht_queue.sv */
// two-entry queue of classified operations between front and back
`default_nettype none

module ffht_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ffht_pkg::op_t push_op,
  output logic               q_ready,
  input  wire logic          pop,
  output logic               q_valid,
  output ffht_pkg::op_t      q_op
);
  import ffht_pkg::*;

  op_t        ents [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_op    = ents[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ents[wr_ptr] <= push_op;
  end

endmodule

`default_nettype wire

/* rtl/core/ffht_back.sv */
// back end: table memory, occupancy bits, free-slot search and result register
`default_nettype none

module ffht_back #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ffht_pkg::op_t q_op,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffht_pkg::out_item_t out_data
);
  import ffht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  state_t                   state;
  op_t                      cur;
  logic [TABLE_SLOTS-1:0]   used;
  logic [IDX_W-1:0]         addr;
  logic                     full;
  logic [WORD_W-1:0]        rd_data;
  logic [WORD_W-1:0]        mem [TABLE_SLOTS];

  logic                     out_free;
  logic                     finish;
  logic [IDX_W-1:0]         free_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [KEY_IDX_W-1:0]     addr_wide;
  out_item_t                res_next;

  // handshake with queue and result register
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_WRITE) && out_free;
  assign pop      = q_valid && ((state == S_IDLE) || finish);

  // lowest empty slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // address of this operation
  assign rd_addr   = (cur.kind == KIND_INSERT) ? free_idx : cur.idx[IDX_W-1:0];
  assign mem_we    = finish && (cur.kind == KIND_INSERT) && !full;
  assign addr_wide = KEY_IDX_W'(addr);

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= cur.value;
    if (state == S_READ) rd_data <= mem[rd_addr];
  end

  // result of the operation in flight
  always_comb begin
    res_next        = '0;
    res_next.status = ST_OK;
    unique case (cur.kind)
      KIND_INSERT: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.slot = addr_wide[SLOT_W-1:0];
        end
      end
      KIND_FIND: begin
        if (!cur.in_range) begin
          res_next.status = ST_BOUNDS;
        end else if (used[addr]) begin
          res_next.word = rd_data;
        end
      end
      KIND_REMOVE: begin
        if (!cur.in_range) begin
          res_next.status = ST_BOUNDS;
        end else if (used[addr]) begin
          res_next.word = rd_data;
        end else begin
          res_next.status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, occupancy bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      used      <= '0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= q_op;
            state <= S_READ;
          end
        end
        S_READ: begin
          addr  <= rd_addr;
          full  <= !free_found;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (finish) begin
            out_data <= res_next;
            if ((cur.kind == KIND_INSERT) && !full) begin
              used[addr] <= (cur.value != '0);
            end else if ((cur.kind == KIND_REMOVE) && cur.in_range && used[addr]) begin
              used[addr] <= 1'b0;
            end
            if (pop) begin
              cur   <= q_op;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/first_free_slot_handle_table_top.sv */
// top level of the first-free-slot handle table
// path: an accepted item goes through the queue, the back end's read and write states and the result register
// the back end handles one item at a time, a memory read then a write, and pops the next as it finishes
// the front queue takes up to 2 items while the back end or output is stalled
// reset: synchronous; occupancy bits clear together, so every slot reads empty
// at once with no clearing pass; memory contents need no reset
`default_nettype none

module first_free_slot_handle_table_top #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffht_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffht_pkg::out_item_t     out_data
);
  import ffht_pkg::*;

  logic q_ready;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_valid;
  op_t  q_op;

  // classify incoming items
  ffht_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_ready (q_ready),
    .push    (push),
    .push_op (push_op)
  );

  // decoupling queue
  ffht_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .q_ready(q_ready),
    .pop    (pop),
    .q_valid(q_valid),
    .q_op   (q_op)
  );

  // table operations
  ffht_back #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* tb/sv/first_free_slot_handle_table_top_test.sv */
// self-checking testbench for the first-free-slot handle table, with a model of the slot table
module first_free_slot_handle_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ffht_pkg::*;

  localparam int TABLE_SLOTS     = 64;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_ITEMS    = 1800;
  localparam int PHASE_ITEMS     = 150;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // model of the slot table and the results still owed by the block
  logic [WORD_W-1:0] table_words [TABLE_SLOTS];
  out_item_t         pending_results [$];
  int                mismatch_count;

  // idling controls shared by the sender, the receiver and the tests
  bit tx_gaps_on;
  bit rx_stalls_on;
  bit hold_off_req;
  int burst_left;

  first_free_slot_handle_table_top #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // apply one operation to the table model and return the result it owes
  function automatic out_item_t apply_table_op(input in_item_t item);
    out_item_t res;
    int        k;
    bit        found;
    res = '0;
    res.status = ST_OK;
    k = item.key;
    found = 1'b0;
    case (kind_t'(item.kind))
      KIND_INSERT: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!found && table_words[i] == '0) begin
            found = 1'b1;
            table_words[i] = item.value;
            res.slot = SLOT_W'(i);
          end
        end
        if (!found) res.status = ST_FULL;
      end
      KIND_FIND: begin
        if (k < 0 || k >= TABLE_SLOTS) res.status = ST_BOUNDS;
        else res.word = table_words[k];
      end
      KIND_REMOVE: begin
        if (k < 0 || k >= TABLE_SLOTS) begin
          res.status = ST_BOUNDS;
        end else if (table_words[k] == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.word = table_words[k];
          table_words[k] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // offer one item, in bursts with random gaps, and record its result once accepted
  task automatic send_item(input in_item_t item);
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_table_op(item));
    @(negedge clk);
  endtask

  task automatic send_op(input kind_t kind, input int key, input logic [WORD_W-1:0] value);
    in_item_t item;
    item.kind  = kind;
    item.key   = KEY_W'(key);
    item.value = value;
    send_item(item);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // key for find or remove: often a held slot, sometimes anything the field allows
  function automatic int pick_key();
    int start;
    int idx;
    if ($urandom_range(0, 99) < 10) return $signed(KEY_W'($urandom()));
    start = $urandom_range(0, TABLE_SLOTS - 1);
    if ($urandom_range(0, 1) == 0) return start;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      idx = (start + i) % TABLE_SLOTS;
      if (table_words[idx] != '0) return idx;
    end
    return start;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom();
  endfunction

  // random operation with a given share of inserts and removes, in percent
  function automatic in_item_t random_item(input int insert_pct, input int remove_pct);
    in_item_t item;
    int       r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) item.kind = KIND_INSERT;
    else if (r < insert_pct + remove_pct) item.kind = KIND_REMOVE;
    else if (r < 97) item.kind = KIND_FIND;
    else item.kind = KIND_NOP;
    item.key   = KEY_W'(pick_key());
    item.value = pick_value();
    return item;
  endfunction

  // receiver: own ready/stall pattern, plus a long hold-off on request
  initial begin : out_ready_pattern
    int  hold_left;
    int  phase_left;
    bit  ready_phase;
    hold_left   = 0;
    phase_left  = 0;
    ready_phase = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!rx_stalls_on) begin
        out_ready <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          ready_phase = !ready_phase;
          phase_left  = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        out_ready <= ready_phase;
        phase_left--;
      end
    end
  end

  // result checker against the oldest owed result
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none owed: slot %0d word %h status %0d",
               out_data.slot, out_data.word, out_data.status);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.slot !== exp_res.slot) begin
          $error("slot: expected %0d, got %0d", exp_res.slot, out_data.slot);
          mismatch_count++;
        end
        if (out_data.word !== exp_res.word) begin
          $error("word: expected %h, got %h", exp_res.word, out_data.word);
          mismatch_count++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // lookups on a freshly reset table, and the unused operation
  task automatic test_empty_table();
    send_op(KIND_FIND, 0, 32'h0);
    send_op(KIND_FIND, TABLE_SLOTS - 1, 32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 0, 32'h0);
    send_op(KIND_REMOVE, TABLE_SLOTS - 1, 32'h1234_5678);
    send_op(KIND_NOP, -1, 32'hFFFF_FFFF);
    send_op(KIND_NOP, 0, 32'h0);
    wait_drained();
  endtask

  // extreme values, zero inserts that leave the slot empty, and slot reuse
  task automatic test_insert_cases();
    send_op(KIND_INSERT, 0, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, -128, 32'h0);
    send_op(KIND_INSERT, 127, 32'h0000_0001);
    send_op(KIND_FIND, 1, 32'h0);
    send_op(KIND_REMOVE, 0, 32'h0);
    send_op(KIND_REMOVE, 0, 32'h0);
    send_op(KIND_INSERT, 5, 32'h8000_0000);
    send_op(KIND_FIND, 0, 32'h0);
    wait_drained();
  endtask

  // keys below zero and at or above the table size
  task automatic test_key_bounds();
    send_op(KIND_FIND, TABLE_SLOTS, 32'h0);
    send_op(KIND_FIND, 127, 32'h0);
    send_op(KIND_FIND, -1, 32'h0);
    send_op(KIND_FIND, -128, 32'h0);
    send_op(KIND_REMOVE, TABLE_SLOTS, 32'h0);
    send_op(KIND_REMOVE, -128, 32'h0);
    wait_drained();
  endtask

  // fill every slot, insert into the full table, then free two slots, refill them and insert into the full table again
  task automatic test_full_table();
    logic [WORD_W-1:0] v;
    for (int i = 0; i < TABLE_SLOTS + 1; i++) begin
      v = $urandom();
      if (v == '0) v = 32'h1;
      send_op(KIND_INSERT, i, v);
    end
    send_op(KIND_INSERT, 0, 32'hDEAD_BEEF);
    send_op(KIND_REMOVE, TABLE_SLOTS / 2, 32'h0);
    send_op(KIND_REMOVE, 3, 32'h0);
    send_op(KIND_INSERT, 0, 32'h0BAD_F00D);
    send_op(KIND_INSERT, 0, 32'h0000_0042);
    send_op(KIND_INSERT, 0, 32'h0000_0043);
    wait_drained();
  endtask

  // long output stall while items keep coming, so the input backs up
  task automatic test_output_backpressure();
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++) send_item(random_item(40, 30));
    wait_drained();
  endtask

  // random phases: fill-heavy, drain-heavy and mixed, with varied idling
  task automatic test_random_ops();
    int insert_pct;
    int remove_pct;
    int phase;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        phase = (n / PHASE_ITEMS) % 3;
        case (phase)
          0: begin insert_pct = 70; remove_pct = 10; end
          1: begin insert_pct = 15; remove_pct = 60; end
          default: begin insert_pct = 35; remove_pct = 35; end
        endcase
        tx_gaps_on   = ($urandom_range(0, 2) != 0);
        rx_stalls_on = ($urandom_range(0, 2) != 0);
      end
      send_item(random_item(insert_pct, remove_pct));
    end
    wait_drained();
  endtask

  // run limit
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    tx_gaps_on     = 1'b1;
    rx_stalls_on   = 1'b1;
    hold_off_req   = 1'b0;
    burst_left     = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) table_words[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_insert_cases();
    test_key_bounds();
    test_full_table();
    test_output_backpressure();
    test_random_ops();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
